### hw/rtl/pseudocolor_ramp_colormap_core_defines.svh
// ----------------------------------------------------------------------------
// Pseudocolor ramp colormap: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PSEUDOCOLOR_RAMP_COLORMAP_CORE_DEFINES_SVH
`define PSEUDOCOLOR_RAMP_COLORMAP_CORE_DEFINES_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define PRCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pseudocolor ramp colormap assertion failed");

// The expression must hold at every clock edge outside reset.
`define PRCM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pseudocolor ramp colormap assertion failed");

`endif

### hw/rtl/prcm_pkg.sv
// ----------------------------------------------------------------------------
// Pseudocolor ramp colormap package
// Fixed-point format, channel ramp starts and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package prcm_pkg;

  localparam int FRAC_BITS = 16;

  localparam int RED_START   = 50;
  localparam int GREEN_START = 16;
  localparam int BLUE_START  = 0;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  localparam cfg_index_t CFG_BLACK_LEVEL   = 2'd0;
  localparam cfg_index_t CFG_INDEX_SCALE   = 2'd1;
  localparam cfg_index_t CFG_COLOUR_STEPS  = 2'd2;
  localparam cfg_index_t CFG_LOCATION_STEP = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/prcm_ramp.sv
// ----------------------------------------------------------------------------
// Pseudocolor ramp colormap: channel ramp
// Two register stages that turn a Q.16 location into one 8-bit channel:
// a slope-of-ten ramp from START, folded down above 255 and clamped at zero,
// optionally inverted.
// ----------------------------------------------------------------------------
`default_nettype none

module prcm_ramp #(
  parameter int LOC_BITS = 40,
  parameter int START    = 0,
  parameter bit INVERT   = 1'b0
) (
  input  wire logic                clk,
  input  wire logic [LOC_BITS-1:0] loc,
  output logic      [7:0]          chan
);
  import prcm_pkg::*;

  localparam int RAMP_BITS = LOC_BITS + 4;

  localparam logic [LOC_BITS-1:0]  START_Q = LOC_BITS'(START) << FRAC_BITS;
  localparam logic [RAMP_BITS-1:0] FULL_Q  = RAMP_BITS'(255) << FRAC_BITS;
  localparam logic [RAMP_BITS-1:0] TOP_Q   = RAMP_BITS'(512) << FRAC_BITS;

  logic [RAMP_BITS-1:0] ramp_next;
  logic [RAMP_BITS-1:0] ramp_q;
  logic [7:0]           chan_next;

  // Stage A: (loc - start) * 10 as a shift-and-add, zero below the start.
  always_comb begin
    logic [RAMP_BITS-1:0] diff;
    diff = {4'b0, loc - START_Q};
    if (loc > START_Q) begin
      ramp_next = (diff << 3) + (diff << 1);
    end else begin
      ramp_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    ramp_q <= ramp_next;
  end

  // Stage B: fold above full scale, then invert if asked, then take the
  // integer part.
  always_comb begin
    logic [RAMP_BITS-1:0] folded;
    logic [RAMP_BITS-1:0] shaped;
    if (ramp_q > FULL_Q) begin
      folded = (ramp_q >= TOP_Q) ? '0 : TOP_Q - ramp_q;
    end else begin
      folded = ramp_q;
    end
    if (INVERT) begin
      shaped = (folded >= FULL_Q) ? '0 : FULL_Q - folded;
    end else begin
      shaped = folded;
    end
    chan_next = shaped[FRAC_BITS+7:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    chan <= chan_next;
  end

endmodule

`default_nettype wire

### hw/rtl/pseudocolor_ramp_colormap_core.sv
// ----------------------------------------------------------------------------
// Pseudocolor ramp colormap core
// Maps monochrome pixels to RGB false color with arithmetic ramps, no table.
// ----------------------------------------------------------------------------
// The core takes one pixel in every clock cycle (busy is always low) and
// delivers its color on red, green and blue with done high for a single
// cycle. The color passes through six register stages: offset,
// offset-by-scale multiply, round and clamp, index-by-step multiply, ramp,
// and fold. The receiver cannot stall, and none is needed. Configuration
// registers are written through cfg_we, cfg_index and cfg_data and should
// only change while no pixel is in flight.
`default_nettype none

`include "pseudocolor_ramp_colormap_core_defines.svh"

module pseudocolor_ramp_colormap_core #(
  parameter int PIXEL_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [PIXEL_BITS-1:0]    pixel,
  output logic                          done,
  output logic      [7:0]               blue,
  output logic      [7:0]               green,
  output logic      [7:0]               red,
  input  wire logic                     cfg_we,
  input  wire prcm_pkg::cfg_index_t     cfg_index,
  input  wire prcm_pkg::cfg_data_t      cfg_data
);
  import prcm_pkg::*;

  localparam int DEPTH     = 6;
  localparam int PROD_BITS = PIXEL_BITS + 32;
  localparam int IDXW_BITS = PROD_BITS + 1 - FRAC_BITS;
  localparam int LOC_BITS  = INDEX_BITS + 24;

  localparam logic [PROD_BITS:0]   ROUND_HALF = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [INDEX_BITS-1:0] IDX_MAX   = '1;

  // Configuration registers.
  logic [15:0] black_level;
  logic [31:0] index_scale;
  logic [16:0] colour_steps;
  logic [23:0] location_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_level   <= 16'd0;
      index_scale   <= 32'd65536;
      colour_steps  <= 17'd5000;
      location_step <= 24'd1311;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLACK_LEVEL:   black_level   <= cfg_data[15:0];
        CFG_INDEX_SCALE:   index_scale   <= cfg_data[31:0];
        CFG_COLOUR_STEPS:  colour_steps  <= cfg_data[16:0];
        CFG_LOCATION_STEP: location_step <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits, one per stage.
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  assign done = vld[DEPTH-1];

  // Stage 1: offset above black level, zero when the pixel is not above it.
  logic [16:0]           pix_ext;
  logic [PIXEL_BITS-1:0] offset_next;
  logic [PIXEL_BITS-1:0] offset_q;

  assign pix_ext = 17'(pixel);

  always_comb begin
    logic [16:0] diff;
    diff = pix_ext - {1'b0, black_level};
    offset_next = (pix_ext > {1'b0, black_level}) ? diff[PIXEL_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    offset_q <= offset_next;
  end

  // Stage 2: offset times Q16.16 scale.
  logic [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk) begin
    prod_q <= PROD_BITS'(offset_q) * PROD_BITS'(index_scale);
  end

  // Stage 3: round half up, saturate to the index range, clamp below steps.
  logic [16:0]           limit;
  logic [INDEX_BITS-1:0] idx_next;
  logic [INDEX_BITS-1:0] idx_q;

  assign limit = (colour_steps == 17'd0) ? 17'd0 : colour_steps - 17'd1;

  always_comb begin
    logic [PROD_BITS:0]    rounded;
    logic [IDXW_BITS-1:0]  idx_wide;
    logic [INDEX_BITS-1:0] idx_sat;
    logic [16:0]           idx_ext;
    rounded  = {1'b0, prod_q} + ROUND_HALF;
    idx_wide = rounded[PROD_BITS:FRAC_BITS];
    if (idx_wide > IDXW_BITS'(IDX_MAX)) begin
      idx_sat = IDX_MAX;
    end else begin
      idx_sat = idx_wide[INDEX_BITS-1:0];
    end
    idx_ext = 17'(idx_sat);
    if (idx_ext > limit) begin
      idx_next = limit[INDEX_BITS-1:0];
    end else begin
      idx_next = idx_sat;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= idx_next;
  end

  // Stage 4: location in Q24.16, nominally on the 0..100 scale, kept at full width.
  logic [LOC_BITS-1:0] loc_q;

  always_ff @(posedge clk) begin
    loc_q <= LOC_BITS'(idx_q) * LOC_BITS'(location_step);
  end

  // Stages 5 and 6: one ramp per channel.
  prcm_ramp #(
    .LOC_BITS (LOC_BITS),
    .START    (BLUE_START),
    .INVERT   (1'b1)
  ) u_ramp_blue (
    .clk  (clk),
    .loc  (loc_q),
    .chan (blue)
  );

  prcm_ramp #(
    .LOC_BITS (LOC_BITS),
    .START    (GREEN_START),
    .INVERT   (1'b0)
  ) u_ramp_green (
    .clk  (clk),
    .loc  (loc_q),
    .chan (green)
  );

  prcm_ramp #(
    .LOC_BITS (LOC_BITS),
    .START    (RED_START),
    .INVERT   (1'b0)
  ) u_ramp_red (
    .clk  (clk),
    .loc  (loc_q),
    .chan (red)
  );

  // A result appears only for an accepted transfer that has passed every stage.
  `PRCM_ASSERT_IMPL(a_done_latency, done, $past(accept, DEPTH))
  // A pixel at or below black level maps to index zero: full blue only.
  `PRCM_ASSERT_IMPL(a_black_color, done && $past(pix_ext <= {1'b0, black_level}, DEPTH),
                    blue == 8'd255 && green == 8'd0 && red == 8'd0)
  // The clamped index never exceeds the configured step count less one (zero when the count is zero).
  `PRCM_ASSERT_ALWAYS(a_index_clamped, !vld[2] || (17'(idx_q) <= limit))

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// Pseudocolor ramp colormap core testbench
// Drives pixels and register writes into the core, predicts each RGB color
// from a shadow copy of the registers, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;

  import prcm_pkg::*;

  localparam int PIXEL_W       = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PIXELS = 1750;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_CONFIG, JOB_PAUSE} job_kind_t;

  typedef struct {
    job_kind_t        kind;
    logic [PIXEL_W-1:0] pixel;
    cfg_index_t       index;
    cfg_data_t        data;
    int unsigned      gap;
  } job_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [PIXEL_W-1:0] pixel = '0;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_BLACK_LEVEL;
  cfg_data_t cfg_data = '0;
  logic busy;
  logic done;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  job_t jobs[$];
  rgb_t colors_due[$];
  int unsigned mismatch_count = 0;
  int unsigned gap_left = 0;
  int unsigned settle = 0;

  // Shadow copy of the configuration registers.
  logic [15:0] black_lvl_q;
  logic [31:0] gain_q;
  logic [16:0] steps_q;
  logic [23:0] loc_step_q;

  pseudocolor_ramp_colormap_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Ramp in Q.16: (location - start) * 10, folded above 255 and clamped at 0.
  function automatic logic [63:0] ramp_q16(input logic [63:0] loc, input int origin);
    logic [63:0] base;
    logic [63:0] v;
    base = 64'(origin) << FRAC_BITS;
    if (loc <= base) return 64'd0;
    v = (loc - base) * 64'd10;
    if (v > (64'd255 << FRAC_BITS)) begin
      v = (v >= (64'd512 << FRAC_BITS)) ? 64'd0 : (64'd512 << FRAC_BITS) - v;
    end
    return v;
  endfunction

  function automatic rgb_t map_pixel(input logic [PIXEL_W-1:0] pix);
    logic [63:0] idx;
    logic [63:0] limit;
    logic [63:0] loc;
    logic [63:0] v;
    rgb_t c;
    idx = 64'd0;
    if (pix > black_lvl_q) begin
      idx = ((64'(pix) - 64'(black_lvl_q)) * 64'(gain_q) + 64'd32768) >> FRAC_BITS;
      if (idx > 64'd65535) idx = 64'd65535;
    end
    limit = (steps_q == 0) ? 64'd0 : 64'(steps_q) - 64'd1;
    if (idx > limit) idx = limit;
    loc = idx * 64'(loc_step_q);
    v = ramp_q16(loc, BLUE_START);
    c.blue  = (v >= (64'd255 << FRAC_BITS)) ? 8'd0
                                            : 8'(((64'd255 << FRAC_BITS) - v) >> FRAC_BITS);
    c.green = 8'(ramp_q16(loc, GREEN_START) >> FRAC_BITS);
    c.red   = 8'(ramp_q16(loc, RED_START) >> FRAC_BITS);
    return c;
  endfunction

  function automatic void push_pixel(input int unsigned pix, input int unsigned gap);
    job_t j;
    j.kind = JOB_PIXEL;
    j.pixel = PIXEL_W'(pix);
    j.index = CFG_BLACK_LEVEL;
    j.data = '0;
    j.gap = gap;
    jobs.push_back(j);
  endfunction

  function automatic void push_config(input cfg_index_t idx, input logic [31:0] value);
    job_t j;
    j.kind = JOB_CONFIG;
    j.pixel = '0;
    j.index = idx;
    j.data = value;
    j.gap = 0;
    jobs.push_back(j);
  endfunction

  // Holds the sender until every expected color has come and the pipe is empty.
  function automatic void push_pause();
    job_t j;
    j.kind = JOB_PAUSE;
    j.pixel = '0;
    j.index = CFG_BLACK_LEVEL;
    j.data = '0;
    j.gap = 0;
    jobs.push_back(j);
  endfunction

  always @(posedge clk) begin : driver
    job_t j;
    logic nx_start;
    logic nx_we;
    logic [PIXEL_W-1:0] nx_pixel;
    cfg_index_t nx_index;
    cfg_data_t nx_data;
    if (rst) begin
      start     <= 1'b0;
      pixel     <= '0;
      cfg_we    <= 1'b0;
      cfg_index <= CFG_BLACK_LEVEL;
      cfg_data  <= '0;
      gap_left  = 0;
      settle    = 0;
    end else begin
      nx_start = start;
      nx_pixel = pixel;
      nx_we    = 1'b0;
      nx_index = cfg_index;
      nx_data  = cfg_data;
      if (start && !busy) nx_start = 1'b0;
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (jobs.size() != 0) begin
          case (jobs[0].kind)
            JOB_PIXEL: begin
              j = jobs.pop_front();
              nx_start = 1'b1;
              nx_pixel = j.pixel;
              gap_left = j.gap;
            end
            JOB_CONFIG: begin
              j = jobs.pop_front();
              nx_we    = 1'b1;
              nx_index = j.index;
              nx_data  = j.data;
            end
            default: begin
              if (!start && colors_due.size() == 0) begin
                if (settle >= SETTLE_CYCLES) begin
                  j = jobs.pop_front();
                  settle = 0;
                end else begin
                  settle++;
                end
              end else begin
                settle = 0;
              end
            end
          endcase
        end
      end
      start     <= nx_start;
      pixel     <= nx_pixel;
      cfg_we    <= nx_we;
      cfg_index <= nx_index;
      cfg_data  <= nx_data;
    end
  end

  always @(posedge clk) begin : monitor
    rgb_t got;
    rgb_t want;
    if (rst) begin
      black_lvl_q = 16'd0;
      gain_q      = 32'd65536;
      steps_q     = 17'd5000;
      loc_step_q  = 24'd1311;
      colors_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLACK_LEVEL:   black_lvl_q = cfg_data[15:0];
          CFG_INDEX_SCALE:   gain_q      = cfg_data[31:0];
          CFG_COLOUR_STEPS:  steps_q     = cfg_data[16:0];
          CFG_LOCATION_STEP: loc_step_q  = cfg_data[23:0];
          default: ;
        endcase
      end
      if (done) begin
        got = '{blue: blue, green: green, red: red};
        if (colors_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected color: b=%0d g=%0d r=%0d", blue, green, red);
          mismatch_count++;
        end else begin
          want = colors_due.pop_front();
          if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red) begin
            if (mismatch_count < 10)
              $display("color mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                       want.blue, want.green, want.red, got.blue, got.green, got.red);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) colors_due.push_back(map_pixel(pixel));
    end
  end

  initial begin : stimulus
    int unsigned random_count;
    int unsigned mode;
    int unsigned n;
    int unsigned gap_style;
    int unsigned black;
    int unsigned span;
    int unsigned steps;
    int unsigned loc_step;
    int unsigned pix_val;
    int pv;
    logic [31:0] scale;
    int unsigned gap;

    // Reset settings: the index follows the pixel and clamps at 4999.
    push_pixel(0, $urandom_range(0, 16));
    push_pixel(1, $urandom_range(0, 16));
    push_pixel(800, 0);
    push_pixel(2500, 0);
    push_pixel(3774, $urandom_range(0, 16));
    push_pixel(3800, 0);
    push_pixel(4999, 0);
    push_pixel(5000, $urandom_range(0, 16));
    push_pixel(65535, 0);

    // Pixels around the black level with a gain of one half: half rounds up.
    push_pause();
    push_config(CFG_BLACK_LEVEL, 32'd1000);
    push_config(CFG_INDEX_SCALE, 32'd32768);
    push_pixel(999, 0);
    push_pixel(1000, 0);
    push_pixel(1001, $urandom_range(0, 16));
    push_pixel(1002, 0);
    push_pixel(1003, 0);

    // Index saturation with 65536 steps and the largest location step.
    push_pause();
    push_config(CFG_BLACK_LEVEL, 32'd0);
    push_config(CFG_INDEX_SCALE, 32'hFFFF_FFFF);
    push_config(CFG_COLOUR_STEPS, 32'd65536);
    push_config(CFG_LOCATION_STEP, 32'h00FF_FFFF);
    push_pixel(1, 0);
    push_pixel(65535, 0);

    // Zero steps and a single step both pin the index at zero.
    push_pause();
    push_config(CFG_COLOUR_STEPS, 32'd0);
    push_pixel(65535, 0);
    push_pause();
    push_config(CFG_COLOUR_STEPS, 32'd1);
    push_pixel(65535, 0);

    // Fold overshoot: a ramp just past 255 folds to just above 255.
    push_pause();
    push_config(CFG_INDEX_SCALE, 32'd65536);
    push_config(CFG_COLOUR_STEPS, 32'd131071);
    push_config(CFG_LOCATION_STEP, 32'd1674445);
    push_pixel(1, 0);
    push_pixel(0, 0);
    push_pause();
    push_config(CFG_LOCATION_STEP, 32'd4951245);
    push_pixel(1, 0);
    push_pixel(2, 0);
    push_pause();
    push_config(CFG_LOCATION_STEP, 32'd2723021);
    push_pixel(1, 0);

    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      mode = $urandom_range(0, 3);
      black = 0;
      span = 65535;
      case (mode)
        0, 1: begin
          // Calibrated as software would set it from a frame's min and max.
          steps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64)
                                              : $urandom_range(2, 65536);
          black = $urandom_range(0, 50000);
          span = $urandom_range(1, 65535 - black);
          scale = 32'(((64'(steps - 1) << 16) + 64'(span / 2)) / 64'(span));
          loc_step = (100 << 16) / steps;
        end
        2: begin
          black = $urandom_range(0, 65535);
          scale = $urandom;
          if ($urandom_range(0, 1) == 1) scale = scale >> $urandom_range(0, 31);
          steps = $urandom_range(0, 131071);
          loc_step = $urandom_range(0, 24'hFF_FFFF);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: black = 0;
            1: black = 65535;
            default: black = $urandom_range(0, 65535);
          endcase
          case ($urandom_range(0, 3))
            0: scale = 32'd0;
            1: scale = 32'hFFFF_FFFF;
            2: scale = 32'd65536;
            default: scale = $urandom;
          endcase
          case ($urandom_range(0, 5))
            0: steps = 0;
            1: steps = 1;
            2: steps = 2;
            3: steps = 65535;
            4: steps = 65536;
            default: steps = 131071;
          endcase
          case ($urandom_range(0, 3))
            0: loc_step = 0;
            1: loc_step = 1;
            2: loc_step = 24'hFF_FFFF;
            default: loc_step = $urandom_range(0, 24'hFF_FFFF);
          endcase
        end
      endcase
      push_pause();
      push_config(CFG_BLACK_LEVEL, 32'(black));
      push_config(CFG_INDEX_SCALE, scale);
      push_config(CFG_COLOUR_STEPS, 32'(steps));
      push_config(CFG_LOCATION_STEP, 32'(loc_step));

      n = $urandom_range(10, 100);
      gap_style = $urandom_range(0, 2);
      repeat (n) begin
        if (mode <= 1 && $urandom_range(0, 3) != 0) begin
          pv = int'(black) - 64 + int'($urandom_range(0, span + 128));
          if (pv < 0) pv = 0;
          if (pv > 65535) pv = 65535;
          pix_val = pv;
        end else begin
          pix_val = $urandom_range(0, 65535);
        end
        case (gap_style)
          0: gap = 0;
          1: gap = $urandom_range(0, 16);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
        endcase
        push_pixel(pix_val, gap);
        random_count++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (jobs.size() != 0 || start) @(posedge clk);
    while (colors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 10) @(posedge clk);

    if (mismatch_count == 0 && colors_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### pseudocolor_ramp_colormap_core.f
+incdir+hw/rtl
hw/rtl/prcm_pkg.sv
hw/rtl/prcm_ramp.sv
hw/rtl/pseudocolor_ramp_colormap_core.sv
verif/tb.sv
